// ===== src/tmd_pkg.sv =====
// Package for the trapezoidal move-duration core: status codes, constants, stage control type.
`default_nettype none
package tmd_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    localparam logic [16:0] RATE_ONE   = 17'd65536;
    localparam logic [31:0] FULL_SCALE = 32'hFFFF_FFFF;

    // Pipeline geometry: one quotient bit per stage, one root bit per stage
    localparam int TRI_STEPS  = 64;
    localparam int TRAP_STEPS = 32;
    localparam int SQ_STEPS   = 32;
    localparam int LAST_STAGE = TRI_STEPS + SQ_STEPS;

    // Per-request flags that travel down the divider and root stages
    typedef struct packed {
        logic inv;       // rejected input
        logic tri_prof;  // triangular profile selected
        logic tri_ovf;   // triangular quotient needs more than 64 bits
        logic trap_ovf;  // a trapezoidal term needs more than 32 bits
    } ctl_t;

endpackage
`default_nettype wire

// ===== src/trapezoid_move_duration_core.sv =====
// Move-duration estimator for a symmetric trapezoidal velocity profile, fully pipelined.
// Stages: 3 product/compare stages, a ramp-test and divider set-up stage,
//   64 restoring-divider stages, 32 square-root stages, output register.
// Throughput: one request per cycle while the output is not stalled; all stages share one advance.
// A stalled output holds the whole chain; nothing is dropped or repeated.
// Reset (synchronous, active low): all valid bits clear, rate_reg returns to 1.0.
`default_nettype none
module trapezoid_move_duration_core
    import tmd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [16:0] cfg_data,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic signed [31:0] s_joint_delta,
    input  wire logic signed [31:0] s_speed,
    input  wire logic signed [31:0] s_acceleration,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_duration,
    output logic [1:0]       m_status
);

    logic        adv;
    logic [16:0] rate_reg;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_ONE;
        end else if (cfg_valid) begin
            rate_reg <= cfg_data;
        end
    end

    // Global advance: the chain moves whenever the output register can take a result
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage A: capture request and check validity
    logic        a_valid_reg;
    logic [30:0] a_d_reg, a_v_reg, a_a_reg;
    logic [16:0] a_r_reg;
    logic        a_inv_reg;
    logic        inv_next;

    always_comb begin
        inv_next = s_joint_delta[31] || s_speed[31] || (s_speed == 32'sd0) ||
                   s_acceleration[31] || (s_acceleration == 32'sd0) ||
                   (rate_reg == 17'd0) || (rate_reg > RATE_ONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_d_reg   <= s_joint_delta[30:0];
            a_v_reg   <= s_speed[30:0];
            a_a_reg   <= s_acceleration[30:0];
            a_r_reg   <= rate_reg;
            a_inv_reg <= inv_next;
        end
    end

    // Stage B: first products
    logic        b_valid_reg;
    logic [30:0] b_d_reg, b_v_reg, b_a_reg;
    logic [16:0] b_r_reg;
    logic        b_inv_reg;
    logic [61:0] b_pda_reg, b_pvv_reg;
    logic [47:0] b_mtri_reg, b_mtrap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_d_reg     <= a_d_reg;
            b_v_reg     <= a_v_reg;
            b_a_reg     <= a_a_reg;
            b_r_reg     <= a_r_reg;
            b_inv_reg   <= a_inv_reg;
            b_pda_reg   <= 62'(a_d_reg) * 62'(a_a_reg);
            b_pvv_reg   <= 62'(a_v_reg) * 62'(a_v_reg);
            b_mtri_reg  <= 48'(a_a_reg) * 48'(a_r_reg);
            b_mtrap_reg <= 48'(a_v_reg) * 48'(a_r_reg);
        end
    end

    // Stage C: split v*v*r, range checks for quotients
    logic        c_valid_reg;
    logic [30:0] c_d_reg, c_v_reg, c_a_reg;
    logic        c_inv_reg;
    logic [61:0] c_pda_reg;
    logic [47:0] c_mtri_reg, c_mtrap_reg;
    logic [47:0] c_vvlo_reg, c_vvhi_reg;
    logic        c_tri_ovf_reg, c_trap_ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_d_reg        <= b_d_reg;
            c_v_reg        <= b_v_reg;
            c_a_reg        <= b_a_reg;
            c_inv_reg      <= b_inv_reg;
            c_pda_reg      <= b_pda_reg;
            c_mtri_reg     <= b_mtri_reg;
            c_mtrap_reg    <= b_mtrap_reg;
            c_vvlo_reg     <= 48'(b_pvv_reg[30:0]) * 48'(b_r_reg);
            c_vvhi_reg     <= 48'(b_pvv_reg[61:31]) * 48'(b_r_reg);
            // quotient >= 2^64 exactly when d >= m * 2^14
            c_tri_ovf_reg  <= {31'd0, b_d_reg} >= {b_mtri_reg, 14'd0};
            // t1 >= 2^32 when v >= a*2^16, t2 >= 2^32 when d >= v*r
            c_trap_ovf_reg <= ({16'd0, b_v_reg} >= {b_a_reg, 16'd0}) ||
                              ({17'd0, b_d_reg} >= b_mtrap_reg);
        end
    end

    // Stage arrays: index 0 is the first divider stage, LAST_STAGE the last root stage
    logic vld_reg [0:LAST_STAGE];
    ctl_t ctl_reg [0:LAST_STAGE];

    logic [47:0] tri_rem_reg [0:TRI_STEPS];
    logic [47:0] tri_dvs_reg [0:TRI_STEPS];
    logic [63:0] tri_nq_reg  [0:TRI_STEPS];

    logic [30:0] t1_rem_reg [0:TRAP_STEPS];
    logic [30:0] t1_dvs_reg [0:TRAP_STEPS];
    logic [31:0] t1_nq_reg  [0:TRAP_STEPS];
    logic [47:0] t2_rem_reg [0:TRAP_STEPS];
    logic [47:0] t2_dvs_reg [0:TRAP_STEPS];
    logic [31:0] t2_nq_reg  [0:TRAP_STEPS];

    logic [32:0] tsum_reg [TRAP_STEPS+1:LAST_STAGE];

    logic [33:0] sq_rem_reg  [TRI_STEPS+1:LAST_STAGE];
    logic [31:0] sq_root_reg [TRI_STEPS+1:LAST_STAGE];
    logic [63:0] sq_nq_reg   [TRI_STEPS+1:LAST_STAGE];

    // Stage D (index 0): ramp test and divider set-up
    logic [78:0] rhs_next;
    logic [78:0] lhs_next;
    ctl_t        ctl0_next;

    always_comb begin
        rhs_next = {c_vvhi_reg, 31'd0} + 79'(c_vvlo_reg);
        lhs_next = {1'b0, c_pda_reg, 16'd0};
        ctl0_next.inv      = c_inv_reg;
        ctl0_next.tri_prof = lhs_next <= rhs_next;
        ctl0_next.tri_ovf  = c_tri_ovf_reg;
        ctl0_next.trap_ovf = c_trap_ovf_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg[0]     <= ctl0_next;
            tri_rem_reg[0] <= 48'(c_d_reg[30:14]);
            tri_dvs_reg[0] <= c_mtri_reg;
            tri_nq_reg[0]  <= {c_d_reg[13:0], 50'd0};
            t1_rem_reg[0]  <= 31'(c_v_reg[30:16]);
            t1_dvs_reg[0]  <= c_a_reg;
            t1_nq_reg[0]   <= {c_v_reg[15:0], 16'd0};
            t2_rem_reg[0]  <= 48'(c_d_reg);
            t2_dvs_reg[0]  <= c_mtrap_reg;
            t2_nq_reg[0]   <= 32'd0;
        end
    end

    // Control and valid bits follow the data through every stage
    for (genvar i = 0; i < LAST_STAGE; i++) begin : g_ctl
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (adv) begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                ctl_reg[i+1] <= ctl_reg[i];
            end
        end
    end

    // Triangular divider: d*2^50 / (a*r), one quotient bit per stage
    for (genvar i = 0; i < TRI_STEPS; i++) begin : g_tri
        logic [48:0] sh_next;
        logic        ge_next;
        logic [48:0] diff_next;
        always_comb begin
            sh_next   = {tri_rem_reg[i], tri_nq_reg[i][63]};
            ge_next   = sh_next >= {1'b0, tri_dvs_reg[i]};
            diff_next = sh_next - {1'b0, tri_dvs_reg[i]};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                tri_rem_reg[i+1] <= ge_next ? diff_next[47:0] : sh_next[47:0];
                tri_dvs_reg[i+1] <= tri_dvs_reg[i];
                tri_nq_reg[i+1]  <= {tri_nq_reg[i][62:0], ge_next};
            end
        end
    end

    // Trapezoidal terms: v*2^16/a and d*2^32/(v*r), 32 quotient bits each
    for (genvar i = 0; i < TRAP_STEPS; i++) begin : g_trap
        logic [31:0] sh1_next, diff1_next;
        logic        ge1_next;
        logic [48:0] sh2_next, diff2_next;
        logic        ge2_next;
        always_comb begin
            sh1_next   = {t1_rem_reg[i], t1_nq_reg[i][31]};
            ge1_next   = sh1_next >= {1'b0, t1_dvs_reg[i]};
            diff1_next = sh1_next - {1'b0, t1_dvs_reg[i]};
            sh2_next   = {t2_rem_reg[i], t2_nq_reg[i][31]};
            ge2_next   = sh2_next >= {1'b0, t2_dvs_reg[i]};
            diff2_next = sh2_next - {1'b0, t2_dvs_reg[i]};
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                t1_rem_reg[i+1] <= ge1_next ? diff1_next[30:0] : sh1_next[30:0];
                t1_dvs_reg[i+1] <= t1_dvs_reg[i];
                t1_nq_reg[i+1]  <= {t1_nq_reg[i][30:0], ge1_next};
                t2_rem_reg[i+1] <= ge2_next ? diff2_next[47:0] : sh2_next[47:0];
                t2_dvs_reg[i+1] <= t2_dvs_reg[i];
                t2_nq_reg[i+1]  <= {t2_nq_reg[i][30:0], ge2_next};
            end
        end
    end

    // Sum of the two terms, then carried alongside the remaining stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            tsum_reg[TRAP_STEPS+1] <= 33'(t1_nq_reg[TRAP_STEPS]) +
                                      33'(t2_nq_reg[TRAP_STEPS]);
        end
    end

    for (genvar i = TRAP_STEPS + 1; i < LAST_STAGE; i++) begin : g_tsum
        always_ff @(posedge aclk) begin
            if (adv) begin
                tsum_reg[i+1] <= tsum_reg[i];
            end
        end
    end

    // Integer square root of the triangular quotient, one root bit per stage
    for (genvar i = TRI_STEPS; i < LAST_STAGE; i++) begin : g_sqrt
        logic [33:0] rem_src;
        logic [31:0] root_src;
        logic [63:0] nq_src;
        logic [35:0] sh_next, trial_next, diff_next;
        logic        ge_next;
        if (i == TRI_STEPS) begin : g_first
            assign rem_src  = 34'd0;
            assign root_src = 32'd0;
            assign nq_src   = tri_nq_reg[TRI_STEPS];
        end else begin : g_rest
            assign rem_src  = sq_rem_reg[i];
            assign root_src = sq_root_reg[i];
            assign nq_src   = sq_nq_reg[i];
        end
        always_comb begin
            sh_next    = {rem_src, nq_src[63:62]};
            trial_next = {2'b00, root_src, 2'b01};
            ge_next    = sh_next >= trial_next;
            diff_next  = sh_next - trial_next;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[i+1]  <= ge_next ? diff_next[33:0] : sh_next[33:0];
                sq_root_reg[i+1] <= {root_src[30:0], ge_next};
                sq_nq_reg[i+1]   <= {nq_src[61:0], 2'b00};
            end
        end
    end

    // Result selection and saturation
    logic [31:0] dur_next;
    status_t     st_next;
    ctl_t        ctl_last;

    always_comb begin
        ctl_last = ctl_reg[LAST_STAGE];
        dur_next = FULL_SCALE;
        st_next  = ST_OK;
        priority if (ctl_last.inv) begin
            st_next = ST_INVALID;
        end else if (ctl_last.tri_prof) begin
            if (ctl_last.tri_ovf) begin
                st_next = ST_SATURATED;
            end else begin
                dur_next = sq_root_reg[LAST_STAGE];
            end
        end else if (ctl_last.trap_ovf || tsum_reg[LAST_STAGE][32]) begin
            st_next = ST_SATURATED;
        end else begin
            dur_next = tsum_reg[LAST_STAGE][31:0];
        end
    end

    // Output register
    logic [31:0] m_duration_reg;
    status_t     m_status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vld_reg[LAST_STAGE];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_duration_reg <= dur_next;
            m_status_reg   <= st_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_duration = m_duration_reg;
    assign m_status   = m_status_reg;

endmodule
`default_nettype wire

// ===== bench/trapezoid_move_duration_checker.sv =====
// Checker for the move-duration core: predicts each result and compares it on the result channel.
`timescale 1ns / 1ps
`default_nettype none
module trapezoid_move_duration_checker
    import tmd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [16:0] cfg_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [31:0] s_joint_delta,
    input  wire logic [31:0] s_speed,
    input  wire logic [31:0] s_acceleration,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_duration,
    input  wire logic [1:0]  m_status,
    output int               fail_count,
    output int               pending_count
);

    typedef struct packed {
        logic [31:0] duration;
        status_t     status;
    } move_time_t;

    logic [16:0] rate_override;
    move_time_t  move_time_q[$];

    assign pending_count = move_time_q.size();

    // Integer square root, floor
    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Expected move time for one request under the current override
    function automatic move_time_t predict_move_time(input logic [31:0] d, input logic [31:0] v,
                                                     input logic [31:0] a, input logic [16:0] r);
        move_time_t  t;
        logic [127:0] lhs;
        logic [127:0] rhs;
        logic [127:0] quot;
        logic [127:0] sum;
        if (d[31] || v[31] || v == 0 || a[31] || a == 0 || r == 0 || r > RATE_ONE) begin
            t.duration = FULL_SCALE;
            t.status   = ST_INVALID;
            return t;
        end
        lhs = (128'(d) * 128'(a)) << 16;
        rhs = 128'(v) * 128'(v) * 128'(r);
        if (lhs <= rhs) begin
            // triangular: quotient must fit 64 bits before the root
            quot = (128'(d) << 50) / (128'(a) * 128'(r));
            if (quot[127:64] != 0) begin
                t.duration = FULL_SCALE;
                t.status   = ST_SATURATED;
            end else begin
                t.duration = root_floor(quot[63:0]);
                t.status   = ST_OK;
            end
        end else begin
            // trapezoidal: terms truncated separately
            sum = (128'(v) << 16) / 128'(a) + (128'(d) << 32) / (128'(v) * 128'(r));
            if (sum > 128'(FULL_SCALE)) begin
                t.duration = FULL_SCALE;
                t.status   = ST_SATURATED;
            end else begin
                t.duration = sum[31:0];
                t.status   = ST_OK;
            end
        end
        return t;
    endfunction

    always @(posedge aclk) begin
        move_time_t exp_t;
        if (!aresetn) begin
            rate_override <= RATE_ONE;
            fail_count    <= 0;
        end else begin
            if (cfg_valid && cfg_ready) rate_override <= cfg_data;
            if (s_valid && s_ready)
                move_time_q.push_back(predict_move_time(s_joint_delta, s_speed,
                                                        s_acceleration, rate_override));
            // compare accepted result with oldest expectation
            if (m_valid && m_ready) begin
                if (move_time_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result: duration %h status %0d",
                                 m_duration, m_status);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_t = move_time_q.pop_front();
                    if (exp_t.duration !== m_duration || exp_t.status !== m_status) begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h/%0d, got %h/%0d",
                                     exp_t.duration, exp_t.status, m_duration, m_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== bench/trapezoid_move_duration_core_test.sv =====
// Testbench top for the move-duration core: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
`default_nettype none
module trapezoid_move_duration_core_test;
    import tmd_pkg::*;

    localparam int LATENCY = 100;
    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_joint_delta;
    logic [31:0] s_speed;
    logic [31:0] s_acceleration;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_duration;
    logic [1:0]  m_status;
    int          fail_count;
    int          pending_count;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    longint      cycle_count;

    trapezoid_move_duration_core u_top (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_joint_delta, .s_speed, .s_acceleration,
        .m_valid, .m_ready, .m_duration, .m_status
    );

    trapezoid_move_duration_checker u_checker (
        .aclk, .aresetn, .cfg_valid, .cfg_ready, .cfg_data,
        .s_valid, .s_ready, .s_joint_delta, .s_speed, .s_acceleration,
        .m_valid, .m_ready, .m_duration, .m_status, .fail_count, .pending_count
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                hold_off_cycles <= hold_off_cycles - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Send one move request, with random idle cycles before it
    task automatic send_move(input logic [31:0] d, input logic [31:0] v, input logic [31:0] a);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_joint_delta  <= d;
        s_speed        <= v;
        s_acceleration <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    task automatic write_rate(input logic [16:0] r);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random field: mostly sensible magnitudes, sometimes any 32-bit value
    function automatic logic [31:0] rand_field(input bit positive);
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return $urandom;
        if (sel == 1) return positive ? 32'd1 + $urandom_range(255) : 32'd0;
        if (sel <= 5) return $urandom_range(32'h00FF_FFFF, 1);
        return $urandom_range(32'h7FFF_FFFF, 1);
    endfunction

    task automatic send_random(input int n);
        logic [31:0] d;
        for (int i = 0; i < n; i++) begin
            d = rand_field(1'b0);
            if ($urandom_range(19) == 0) d = 32'd0;
            send_move(d, rand_field(1'b1), rand_field(1'b1));
        end
    endtask

    initial begin
        logic [16:0] rates[6];
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_joint_delta = '0;
        s_speed = '0;
        s_acceleration = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, invalid fields, zero travel, both profiles
        send_move(32'd0, 32'h0001_0000, 32'h0001_0000);
        send_move(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        send_move(32'h000A_0000, 32'h0001_0000, 32'h0001_0000);
        send_move(32'h8000_0000, 32'h0001_0000, 32'h0001_0000);
        send_move(32'h0001_0000, 32'd0, 32'h0001_0000);
        send_move(32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_0000);
        send_move(32'h0001_0000, 32'h0001_0000, 32'd0);
        send_move(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
        send_move(32'h7FFF_FFFF, 32'd1, 32'd1);
        send_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
        send_move(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_move(32'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_move(32'd1, 32'd1, 32'h7FFF_FFFF);
        send_move(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_move(32'h0003_0000, 32'h0002_0000, 32'h0004_0000);
        drain_results();

        // Override sweep including zero and out-of-range values
        rates = '{17'd0, 17'd1, 17'h1FFFF, 17'd65537, 17'd32768, RATE_ONE};
        foreach (rates[k]) begin
            write_rate(rates[k]);
            send_move(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
            send_move(32'h7FFF_FFFF, 32'd1, 32'd1);
            send_move(32'h0000_0100, 32'h7FFF_FFFF, 32'h0000_1000);
            drain_results();
        end

        // Random phases with differing idling
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                3: begin send_idle_pct = 12; recv_stall_pct = 12; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) write_rate(17'd1 + 17'($urandom_range(65535)));
            else if (ph == 2) write_rate(17'd40000);
            if (ph == 4) hold_off_cycles <= 400;
            send_random(250);
            drain_results();
            if (ph == 2) write_rate(RATE_ONE);
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
`default_nettype wire
